@@ rtl/incremental_pid_controller_defines.svh @@
// Assertion macros for the incremental PID controller.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef INCREMENTAL_PID_CONTROLLER_DEFINES_SVH
`define INCREMENTAL_PID_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define IPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipid check failed");
`define IPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipid check failed");
`else
`define IPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ipid_pkg.sv @@
`default_nettype none
package ipid_pkg;

  // Field and register widths.
  localparam int DATA_W     = 32;
  localparam int DT_W       = 24;
  localparam int LIM_W      = 31;
  localparam int CFG_ADDR_W = 3;
  localparam int Q_FRAC     = 16;
  localparam int PROD_W     = 65;
  localparam int SUM_W      = 52;
  localparam int WIDE_W     = 66;
  localparam int QUOT_W     = 49;

  // Divider geometry: a 48-bit numerator, two quotient bits per cycle.
  localparam int DIV_NUM_W     = DATA_W + Q_FRAC;
  localparam int DIV_BITS      = 2;
  localparam int DIV_CYCLES    = DIV_NUM_W / DIV_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_VALUE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT  = 3'd5;

  // Reset values of the tuning registers.
  localparam logic [DT_W-1:0]  DT_RESET  = 24'd65536;
  localparam logic [LIM_W-1:0] LIM_RESET = 31'd13107200;

  // Request kinds carried on the input tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Datapath operations issued by the controller.
  typedef logic [3:0] ipid_op_t;
  localparam ipid_op_t OP_NONE = 4'd0;
  localparam ipid_op_t OP_ERR  = 4'd1;
  localparam ipid_op_t OP_DIFF = 4'd2;
  localparam ipid_op_t OP_MLO  = 4'd3;
  localparam ipid_op_t OP_MHI  = 4'd4;
  localparam ipid_op_t OP_MP   = 4'd5;
  localparam ipid_op_t OP_MI1  = 4'd6;
  localparam ipid_op_t OP_MI2  = 4'd7;
  localparam ipid_op_t OP_IADD = 4'd8;
  localparam ipid_op_t OP_DADD = 4'd9;
  localparam ipid_op_t OP_FIN  = 4'd10;
  localparam ipid_op_t OP_CLR  = 4'd11;

  typedef struct packed {
    ipid_op_t op;
  } ipid_cmd_t;

  typedef struct packed {
    logic div_busy;
  } ipid_sts_t;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ipid_div.sv @@
`default_nettype none
module ipid_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ipid_pkg::DATA_W-1:0] dividend,
  input  logic        [ipid_pkg::DT_W-1:0]   divisor,
  output logic                             busy,
  output logic signed [ipid_pkg::QUOT_W-1:0] quot
);
  import ipid_pkg::*;

  logic                   busy_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   neg_r;
  logic [DT_W-1:0]        dvs_r;
  logic [DT_W-1:0]        rem_r;
  logic [DIV_NUM_W-1:0]   num_r;

  logic [DATA_W-1:0]      mag;
  logic [DT_W-1:0]        dvs_in;
  logic [DT_W-1:0]        rem_nxt;
  logic [DIV_NUM_W-1:0]   num_nxt;
  logic [DT_W:0]          trial;

  // Magnitude of the dividend; a zero period counts as the smallest step.
  assign mag    = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
  assign dvs_in = (divisor == '0) ? DT_W'(1) : divisor;

  // Two restoring steps per cycle; quotient bits shift in behind the numerator.
  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    trial   = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      trial   = {rem_nxt, num_nxt[DIV_NUM_W-1]};
      num_nxt = {num_nxt[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt    = DT_W'(trial - {1'b0, dvs_r});
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DT_W-1:0];
      end
    end
  end

  // Control: a start sets busy, which clears once the step counter reaches its last value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DATA_W-1];
      dvs_r <= dvs_in;
      rem_r <= '0;
      num_r <= {mag, {Q_FRAC{1'b0}}};
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  // The quotient truncates toward zero, so the sign is applied to the magnitude.
  assign quot = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
  assign busy = busy_r;

endmodule
`default_nettype wire

@@ rtl/ipid_dp.sv @@
`default_nettype none
module ipid_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ipid_pkg::ipid_cmd_t                 cmd,
  output ipid_pkg::ipid_sts_t                 sts,
  input  logic signed [ipid_pkg::DATA_W-1:0]  meas,
  input  logic signed [ipid_pkg::DATA_W-1:0]  kp,
  input  logic signed [ipid_pkg::DATA_W-1:0]  ki,
  input  logic signed [ipid_pkg::DATA_W-1:0]  kd,
  input  logic signed [ipid_pkg::DATA_W-1:0]  target,
  input  logic        [ipid_pkg::DT_W-1:0]    dt,
  input  logic        [ipid_pkg::LIM_W-1:0]   lim,
  output logic        [ipid_pkg::DATA_W-1:0]  result
);
  import ipid_pkg::*;

  // Controller state and working registers.
  logic signed [DATA_W-1:0] e_r;
  logic signed [DATA_W-1:0] e1_r;
  logic signed [DATA_W-1:0] e2_r;
  logic signed [DATA_W-1:0] acc_r;
  logic signed [DATA_W:0]   d1_r;
  logic signed [DATA_W+2:0] d2_r;
  logic signed [DATA_W:0]   lo_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic        [DATA_W-1:0] res_r;

  logic signed [DATA_W-1:0] err_sat;
  logic signed [DATA_W:0]   d1;
  logic signed [DATA_W+2:0] d2;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W:0]   mul_b;
  logic signed [PROD_W-1:0] mul_prod;
  logic signed [DATA_W-1:0] ie;
  logic signed [DATA_W-1:0] de;
  logic signed [QUOT_W-1:0] term;
  logic signed [QUOT_W-1:0] quot;
  logic signed [SUM_W-1:0]  lim_s;
  logic signed [DATA_W-1:0] acc_nxt;
  logic        [DT_W-1:0]   dt_eff;
  logic                     div_busy;

  // A zero sample period counts as the smallest step.
  assign dt_eff = (dt == '0) ? DT_W'(1) : dt;

  // Error and its first and second differences.
  assign err_sat = sat32(WIDE_W'(target) - WIDE_W'(meas));
  assign d1      = (DATA_W+1)'(e_r) - (DATA_W+1)'(e1_r);
  assign d2      = (DATA_W+3)'(e_r) - ((DATA_W+3)'(e1_r) <<< 1) + (DATA_W+3)'(e2_r);

  // Scaled products: the multiply result shifted down by the fraction bits.
  assign term = $signed(prod_r[PROD_W-1:Q_FRAC]);
  assign ie   = sat32(WIDE_W'(term));
  assign de   = sat32(WIDE_W'($signed(prod_r[SUM_W-1:0])) + WIDE_W'(lo_r));

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.op)
      OP_MLO: begin
        mul_a = kd;
        mul_b = $signed({17'd0, d2_r[Q_FRAC-1:0]});
      end
      OP_MHI: begin
        mul_a = kd;
        mul_b = (DATA_W+1)'($signed(d2_r[DATA_W+2:Q_FRAC]));
      end
      OP_MP: begin
        mul_a = kp;
        mul_b = d1_r;
      end
      OP_MI1: begin
        mul_a = ki;
        mul_b = (DATA_W+1)'(e_r);
      end
      OP_MI2: begin
        mul_a = ie;
        mul_b = $signed({9'd0, dt_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_prod = mul_a * mul_b;

  // Clamp of the accumulated sum to the symmetric limit.
  assign lim_s = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
  always_comb begin
    if (sum_r > lim_s) begin
      acc_nxt = $signed({1'b0, lim});
    end else if (sum_r < -lim_s) begin
      acc_nxt = -$signed({1'b0, lim});
    end else begin
      acc_nxt = sum_r[DATA_W-1:0];
    end
  end

  // Working registers follow the operation sequence.
  always_ff @(posedge clk) begin
    prod_r <= mul_prod;
    case (cmd.op)
      OP_ERR: begin
        e_r <= err_sat;
      end
      OP_DIFF: begin
        d1_r <= d1;
        d2_r <= d2;
      end
      OP_MHI: begin
        lo_r <= $signed(prod_r[DATA_W+Q_FRAC:Q_FRAC]);
      end
      OP_MI1: begin
        sum_r <= SUM_W'(acc_r) + SUM_W'(term);
      end
      OP_IADD: begin
        sum_r <= sum_r + SUM_W'(term);
      end
      OP_DADD: begin
        sum_r <= sum_r + SUM_W'(quot);
      end
      OP_FIN: begin
        res_r <= acc_nxt;
      end
      OP_CLR: begin
        res_r <= '0;
      end
      default: begin
      end
    endcase
  end

  // Error history and accumulated output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r  <= '0;
      e2_r  <= '0;
      acc_r <= '0;
    end else if (cmd.op == OP_FIN) begin
      e1_r  <= e_r;
      e2_r  <= e1_r;
      acc_r <= acc_nxt;
    end else if (cmd.op == OP_CLR) begin
      e1_r  <= '0;
      e2_r  <= '0;
      acc_r <= '0;
    end
  end

  // Derivative term: saturated kd product scaled by 1/dt.
  ipid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_MP),
    .dividend (de),
    .divisor  (dt),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign sts.div_busy = div_busy;
  assign result       = res_r;

endmodule
`default_nettype wire

@@ rtl/ipid_ctrl.sv @@
`default_nettype none
module ipid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_kind,
  output logic                out_tvalid,
  input  logic                out_tready,
  output ipid_pkg::ipid_cmd_t cmd,
  input  ipid_pkg::ipid_sts_t sts
);
  import ipid_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIFF  = 4'd1;
  localparam logic [3:0] ST_MLO   = 4'd2;
  localparam logic [3:0] ST_MHI   = 4'd3;
  localparam logic [3:0] ST_MP    = 4'd4;
  localparam logic [3:0] ST_MI1   = 4'd5;
  localparam logic [3:0] ST_MI2   = 4'd6;
  localparam logic [3:0] ST_IADD  = 4'd7;
  localparam logic [3:0] ST_DWAIT = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_CLR   = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       slot_free;
  logic       commit;

  // The output register can take a result when empty or being drained.
  assign slot_free = !out_vld_r || out_tready;

  // Sequence of datapath operations for one request.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_kind == CMD_CLEAR) begin
            state_nxt = ST_CLR;
          end else begin
            cmd.op    = OP_ERR;
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        cmd.op    = OP_MLO;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        cmd.op    = OP_MHI;
        state_nxt = ST_MP;
      end
      ST_MP: begin
        cmd.op    = OP_MP;
        state_nxt = ST_MI1;
      end
      ST_MI1: begin
        cmd.op    = OP_MI1;
        state_nxt = ST_MI2;
      end
      ST_MI2: begin
        cmd.op    = OP_MI2;
        state_nxt = ST_IADD;
      end
      ST_IADD: begin
        cmd.op    = OP_IADD;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_DADD;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.op    = OP_FIN;
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (slot_free) begin
          cmd.op    = OP_CLR;
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (commit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;

endmodule
`default_nettype wire

@@ rtl/incremental_pid_controller.sv @@
// Incremental (velocity form) PID controller in signed Q16.16. Each sample request
// forms e = target_value - measurement, adds kp*(e-e1) + ki*e*dt + kd*(e-2*e1+e2)/dt
// to the running output, clamps it to plus or minus the output limit and returns it; a
// clear request zeroes the history and returns 0. A sample runs the error and difference
// steps, then five passes through the single 32x33 multiplier; from the third pass on,
// the two-bits-per-cycle divider scales the derivative term by 1/dt alongside them, and
// the final add and clamp follow once it is done. One request is in work at a time; a new
// one is accepted as soon as the previous result sits in the output register, even if
// it has not been taken. A sample period of zero acts as the smallest step. Registers
// are to be written only while no request is in work; the block does not enforce this.
`default_nettype none
`include "incremental_pid_controller_defines.svh"
module incremental_pid_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ipid_pkg::DATA_W-1:0]          in_tdata,   // [31:0] measurement
  input  logic [0:0]                           in_tuser,   // [0] command
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ipid_pkg::DATA_W-1:0]          out_tdata,  // [31:0] control_output
  input  logic                                 cfg_wr_en,
  input  logic [ipid_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ipid_pkg::DATA_W-1:0]          cfg_wdata
);
  import ipid_pkg::*;

  logic [DATA_W-1:0] kp_r;
  logic [DATA_W-1:0] ki_r;
  logic [DATA_W-1:0] kd_r;
  logic [DATA_W-1:0] target_r;
  logic [DT_W-1:0]   dt_r;
  logic [LIM_W-1:0]  lim_r;

  ipid_cmd_t cmd;
  ipid_sts_t sts;

  // Tuning registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
      target_r <= '0;
      dt_r     <= DT_RESET;
      lim_r    <= LIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_PROP_GAIN:     kp_r     <= cfg_wdata;
        REG_INTEG_GAIN:    ki_r     <= cfg_wdata;
        REG_DERIV_GAIN:    kd_r     <= cfg_wdata;
        REG_TARGET_VALUE:  target_r <= cfg_wdata;
        REG_SAMPLE_PERIOD: dt_r     <= cfg_wdata[DT_W-1:0];
        REG_OUTPUT_LIMIT:  lim_r    <= cfg_wdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ipid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  ipid_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .meas   ($signed(in_tdata)),
    .kp     ($signed(kp_r)),
    .ki     ($signed(ki_r)),
    .kd     ($signed(kd_r)),
    .target ($signed(target_r)),
    .dt     (dt_r),
    .lim    (lim_r),
    .result (out_tdata)
  );

  // One request at a time: input closes right after an acceptance.
  `IPID_ASSERT_NXT(a_one_in_work, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // The divider is running once the derivative operand has been issued.
  `IPID_ASSERT_NXT(a_div_started, clk, rst_n, cmd.op == OP_MP, sts.div_busy)
  // The derivative quotient is only added after the divider finished.
  `IPID_ASSERT_IMP(a_div_done, clk, rst_n, cmd.op == OP_DADD, !sts.div_busy)
  // A result is only written when the output register has room.
  `IPID_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.op == OP_FIN || cmd.op == OP_CLR,
                   !out_tvalid || out_tready)

endmodule
`default_nettype wire
